// ===== src/pts_pkg.sv =====
// shared types and constants for the periodic timer scheduler
package pts_pkg;

	localparam int TimeW   = 48;
	localparam int PeriodW = 32;
	localparam int CmdW    = 2;
	localparam int SlotW   = 3;

	localparam logic [TimeW-1:0] EmptyWaitMs = TimeW'(1000 * 60);

	localparam logic [CmdW-1:0] CMD_START = 2'd0;
	localparam logic [CmdW-1:0] CMD_STOP  = 2'd1;
	localparam logic [CmdW-1:0] CMD_CHECK = 2'd2;

	localparam logic KIND_FIRE = 1'b0;
	localparam logic KIND_WAIT = 1'b1;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [2:0] {
		BANK_NONE,
		BANK_LOAD,
		BANK_ADVANCE,
		BANK_STOP,
		BANK_DROP
	} bank_op_t;

	typedef struct packed {
		bank_op_t             op;
		logic [TimeW-1:0]     deadline;
		logic [PeriodW-1:0]   period;
	} bank_wr_t;

endpackage

// ===== src/pts_alu.sv =====
// shared 48-bit adder: saturating add, or subtract with borrow used as a compare
module pts_alu (
	input  pts_pkg::alu_op_t              op,
	input  logic [pts_pkg::TimeW-1:0]     a,
	input  logic [pts_pkg::TimeW-1:0]     b,
	output logic [pts_pkg::TimeW-1:0]     res,
	output logic                          lt
);

	logic                        sub;
	logic [pts_pkg::TimeW:0]     sum;

	assign sub = (op == pts_pkg::ALU_SUB);
	assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{pts_pkg::TimeW{1'b0}}, sub};

	// a < b when the subtract borrows
	assign lt = sub & ~sum[pts_pkg::TimeW];

	always_comb begin
		if (!sub && sum[pts_pkg::TimeW]) begin
			res = '1;
		end else begin
			res = sum[pts_pkg::TimeW-1:0];
		end
	end

endmodule

// ===== src/pts_bank.sv =====
// per-slot timer state: deadline, period, running and queued flags
module pts_bank #(
	parameter int NUM_SLOTS = 8,
	parameter int IdxW      = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [IdxW-1:0]               rd_idx,
	output logic [pts_pkg::TimeW-1:0]     rd_deadline,
	output logic [pts_pkg::PeriodW-1:0]   rd_period,
	output logic                          rd_running,
	output logic                          rd_queued,
	input  logic [IdxW-1:0]               wr_idx,
	input  pts_pkg::bank_wr_t             wr
);

	logic [pts_pkg::TimeW-1:0]   deadline_q [NUM_SLOTS];
	logic [pts_pkg::PeriodW-1:0] period_q   [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]        running_q;
	logic [NUM_SLOTS-1:0]        queued_q;

	assign rd_deadline = deadline_q[rd_idx];
	assign rd_period   = period_q[rd_idx];
	assign rd_running  = running_q[rd_idx];
	assign rd_queued   = queued_q[rd_idx];

	// payload, only read behind a set flag
	always_ff @(posedge clk) begin
		case (wr.op)
			pts_pkg::BANK_LOAD: begin
				deadline_q[wr_idx] <= wr.deadline;
				period_q[wr_idx]   <= wr.period;
			end
			pts_pkg::BANK_ADVANCE: begin
				deadline_q[wr_idx] <= wr.deadline;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			queued_q  <= '0;
		end else begin
			case (wr.op)
				pts_pkg::BANK_LOAD: begin
					running_q[wr_idx] <= 1'b1;
					queued_q[wr_idx]  <= 1'b1;
				end
				pts_pkg::BANK_STOP: begin
					running_q[wr_idx] <= 1'b0;
				end
				pts_pkg::BANK_DROP: begin
					queued_q[wr_idx] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/periodic_timer_scheduler_core.sv =====
// top level of the periodic timer scheduler: command sequencer around the shared adder
//
// A bank of NUM_SLOTS periodic timers driven by commands. A command is taken
// when start is high and busy is low. Start (cmd 0) loads a slot's period and
// sets its deadline to now_ms + period_ms, saturating at 2^48-1; it holds busy
// for one cycle. Stop (cmd 1) clears the slot's running flag and is done in
// the accept cycle; the stale entry stays queued and is dropped silently when
// it falls due. Start or stop on a slot at or above NUM_SLOTS, and cmd 3,
// do nothing. Check (cmd 2) produces one or more result beats, each shown on
// the result ports for exactly one cycle with strobe high; the receiver
// cannot stall, so every strobed beat must be captured on the spot. A fire
// beat (kind 0, last 0) carries the slot that expired, in ascending deadline
// order with ties going to the lowest slot; a running slot's deadline moves
// on by one period each time it fires, so it may fire again in the same
// check. Every check closes with one wait beat (kind 1, last 1) giving the
// time to the next queued deadline, 60000 when nothing is queued, or 0 when
// MAX_FIRES firings were reached while a running timer is still due.
// All arithmetic goes through one 48-bit adder, and the earliest deadline
// is found by a scan that reads one slot per cycle. Each firing passes
// through scan, compare and advance, each silent drop through scan and
// compare, and the closing wait beat through scan, compare and, for a
// pending deadline, the subtract. The wait beat of a check shows in the
// cycle busy drops.
module periodic_timer_scheduler_core #(
	parameter int NUM_SLOTS = 8,
	parameter int MAX_FIRES = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pts_pkg::CmdW-1:0]      cmd,
	input  logic [pts_pkg::SlotW-1:0]     slot,
	input  logic [pts_pkg::PeriodW-1:0]   period_ms,
	input  logic [pts_pkg::TimeW-1:0]     now_ms,
	output logic                          strobe,
	output logic                          kind,
	output logic [pts_pkg::SlotW-1:0]     fired_slot,
	output logic [pts_pkg::TimeW-1:0]     wait_ms,
	output logic                          last
);

	localparam int IdxW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int FireW = $clog2(MAX_FIRES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DECIDE,
		ST_REMAIN,
		ST_ADVANCE
	} state_t;

	state_t                          state_q;

	// captured command operands
	logic [pts_pkg::PeriodW-1:0]     per_q;
	logic [pts_pkg::TimeW-1:0]       now_q;

	// scan bookkeeping: earliest queued entry seen so far
	logic [IdxW-1:0]                 scan_q;
	logic [IdxW-1:0]                 best_q;
	logic [pts_pkg::TimeW-1:0]       best_dl_q;
	logic                            found_q;
	logic [FireW-1:0]                fires_q;

	// registered result beat
	logic                            strobe_q;
	logic                            kind_q;
	logic [pts_pkg::SlotW-1:0]       fired_slot_q;
	logic [pts_pkg::TimeW-1:0]       wait_q;
	logic                            last_q;

	logic                            accept;
	logic                            slot_ok;
	logic [IdxW-1:0]                 in_idx;

	logic [IdxW-1:0]                 rd_idx;
	logic [pts_pkg::TimeW-1:0]       rd_deadline;
	logic [pts_pkg::PeriodW-1:0]     rd_period;
	logic                            rd_running;
	logic                            rd_queued;
	logic [IdxW-1:0]                 wr_idx;
	pts_pkg::bank_wr_t               wr;

	pts_pkg::alu_op_t                alu_op;
	logic [pts_pkg::TimeW-1:0]       alu_a;
	logic [pts_pkg::TimeW-1:0]       alu_b;
	logic [pts_pkg::TimeW-1:0]       alu_res;
	logic                            alu_lt;

	logic                            take;
	logic                            scan_end;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start & ~busy;
	assign slot_ok    = (32'(slot) < NUM_SLOTS);
	assign in_idx     = IdxW'(slot);

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign fired_slot = fired_slot_q;
	assign wait_ms    = wait_q;
	assign last       = last_q;

	// scan walks the slots; every other step looks at the chosen one
	assign rd_idx   = (state_q == ST_SCAN) ? scan_q : best_q;
	assign wr_idx   = (state_q == ST_IDLE) ? in_idx : best_q;
	assign scan_end = (scan_q == IdxW'(NUM_SLOTS - 1));

	// strict less-than keeps the lowest slot on equal deadlines
	assign take = rd_queued & (~found_q | alu_lt);

	// operand routing for the shared adder
	always_comb begin
		alu_op = pts_pkg::ALU_SUB;
		alu_a  = rd_deadline;
		alu_b  = best_dl_q;
		case (state_q)
			ST_LOAD: begin
				alu_op = pts_pkg::ALU_ADD;
				alu_a  = now_q;
				alu_b  = {{(pts_pkg::TimeW - pts_pkg::PeriodW){1'b0}}, per_q};
			end
			ST_DECIDE: begin
				// now < deadline means not yet due
				alu_a = now_q;
				alu_b = best_dl_q;
			end
			ST_REMAIN: begin
				alu_a = best_dl_q;
				alu_b = now_q;
			end
			ST_ADVANCE: begin
				alu_op = pts_pkg::ALU_ADD;
				alu_a  = best_dl_q;
				alu_b  = {{(pts_pkg::TimeW - pts_pkg::PeriodW){1'b0}}, rd_period};
			end
			default: begin
			end
		endcase
	end

	// slot bank writes
	always_comb begin
		wr.op       = pts_pkg::BANK_NONE;
		wr.deadline = alu_res;
		wr.period   = per_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == pts_pkg::CMD_STOP && slot_ok) begin
					wr.op = pts_pkg::BANK_STOP;
				end
			end
			ST_LOAD: begin
				wr.op = pts_pkg::BANK_LOAD;
			end
			ST_DECIDE: begin
				if (found_q && !alu_lt && !rd_running) begin
					wr.op = pts_pkg::BANK_DROP;
				end
			end
			ST_ADVANCE: begin
				wr.op = pts_pkg::BANK_ADVANCE;
			end
			default: begin
			end
		endcase
	end

	pts_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.lt  (alu_lt)
	);

	pts_bank #(
		.NUM_SLOTS (NUM_SLOTS),
		.IdxW      (IdxW)
	) u_bank (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_idx      (rd_idx),
		.rd_deadline (rd_deadline),
		.rd_period   (rd_period),
		.rd_running  (rd_running),
		.rd_queued   (rd_queued),
		.wr_idx      (wr_idx),
		.wr          (wr)
	);

	// sequencer state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			per_q        <= '0;
			now_q        <= '0;
			scan_q       <= '0;
			best_q       <= '0;
			best_dl_q    <= '0;
			found_q      <= 1'b0;
			fires_q      <= '0;
			strobe_q     <= 1'b0;
			kind_q       <= pts_pkg::KIND_FIRE;
			fired_slot_q <= '0;
			wait_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						per_q   <= period_ms;
						now_q   <= now_ms;
						best_q  <= in_idx;
						scan_q  <= '0;
						found_q <= 1'b0;
						fires_q <= '0;
						if (cmd == pts_pkg::CMD_START && slot_ok) begin
							state_q <= ST_LOAD;
						end else if (cmd == pts_pkg::CMD_CHECK) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (take) begin
						best_q    <= scan_q;
						best_dl_q <= rd_deadline;
						found_q   <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DECIDE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					scan_q  <= '0;
					found_q <= 1'b0;
					if (!found_q) begin
						// queue empty
						strobe_q     <= 1'b1;
						kind_q       <= pts_pkg::KIND_WAIT;
						fired_slot_q <= '0;
						wait_q       <= pts_pkg::EmptyWaitMs;
						last_q       <= 1'b1;
						state_q      <= ST_IDLE;
					end else if (alu_lt) begin
						state_q <= ST_REMAIN;
					end else if (!rd_running) begin
						// stopped entry dropped, look again
						state_q <= ST_SCAN;
					end else if (fires_q >= FireW'(MAX_FIRES)) begin
						strobe_q     <= 1'b1;
						kind_q       <= pts_pkg::KIND_WAIT;
						fired_slot_q <= '0;
						wait_q       <= '0;
						last_q       <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						strobe_q     <= 1'b1;
						kind_q       <= pts_pkg::KIND_FIRE;
						fired_slot_q <= pts_pkg::SlotW'(best_q);
						wait_q       <= '0;
						last_q       <= 1'b0;
						fires_q      <= fires_q + 1'b1;
						state_q      <= ST_ADVANCE;
					end
				end
				ST_REMAIN: begin
					strobe_q     <= 1'b1;
					kind_q       <= pts_pkg::KIND_WAIT;
					fired_slot_q <= '0;
					wait_q       <= alu_res;
					last_q       <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_ADVANCE: begin
					state_q <= ST_SCAN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// a beat is final exactly when it is a wait report
	a_last_is_wait: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last == (kind == pts_pkg::KIND_WAIT)))
		else $error("last and kind disagree");

	// a fire beat never ends the check
	a_fire_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == pts_pkg::KIND_FIRE |-> busy)
		else $error("fire beat after check ended");

	// the closing beat frees the block for the next command
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy after final beat");

	// an accepted check always keeps the block busy next cycle
	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == pts_pkg::CMD_CHECK |=> busy && !strobe)
		else $error("check not started");

	// firing count never passes the limit
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fires_q <= FireW'(MAX_FIRES))
		else $error("firing count over limit");
`endif

endmodule

// ===== dv/periodic_timer_scheduler_core_test.sv =====
// testbench for the periodic timer scheduler core: directed and random commands checked beat by beat
module periodic_timer_scheduler_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumSlots   = 8;
	localparam int MaxFires   = 63;
	localparam int IdleLimit  = 3000;	// cycles with no beat on either side
	localparam int TailCycles = 40;	// cycles to wait after the last report before the summary

	// cmd 3 has no meaning in the block and must be swallowed silently
	localparam logic [pts_pkg::CmdW-1:0] CMD_NOP = 2'd3;
	localparam logic [pts_pkg::TimeW-1:0] TimeMax = '1;

	// one command beat plus the sender's pacing around it
	typedef struct {
		logic [pts_pkg::CmdW-1:0]    cmd;
		logic [pts_pkg::SlotW-1:0]   slot;
		logic [pts_pkg::PeriodW-1:0] period;
		logic [pts_pkg::TimeW-1:0]   now;
		bit                          drain;	// hold this one back until every report is in
		int                          gap;	// idle cycles after this beat is taken
	} timer_cmd_t;

	// one result beat as the block should show it
	typedef struct packed {
		logic                        kind;
		logic [pts_pkg::SlotW-1:0]   fired_slot;
		logic [pts_pkg::TimeW-1:0]   wait_ms;
		logic                        last;
	} sched_beat_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [pts_pkg::CmdW-1:0]    cmd = '0;
	logic [pts_pkg::SlotW-1:0]   slot = '0;
	logic [pts_pkg::PeriodW-1:0] period_ms = '0;
	logic [pts_pkg::TimeW-1:0]   now_ms = '0;
	logic                        strobe;
	logic                        kind;
	logic [pts_pkg::SlotW-1:0]   fired_slot;
	logic [pts_pkg::TimeW-1:0]   wait_ms;
	logic                        last;

	periodic_timer_scheduler_core #(
		.NUM_SLOTS(NumSlots),
		.MAX_FIRES(MaxFires)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.slot(slot),
		.period_ms(period_ms),
		.now_ms(now_ms),
		.strobe(strobe),
		.kind(kind),
		.fired_slot(fired_slot),
		.wait_ms(wait_ms),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// timer bank as the testbench believes it to be
	logic [pts_pkg::TimeW-1:0]   tmr_deadline [NumSlots];
	logic [pts_pkg::PeriodW-1:0] tmr_period [NumSlots];
	bit                          tmr_running [NumSlots];
	bit                          tmr_queued [NumSlots];

	timer_cmd_t  cmd_queue[$];	// commands not yet handed to the block
	sched_beat_t sched_reports[$];	// fire and wait beats still owed by the block
	timer_cmd_t  cur_cmd;
	int          gap_left = 0;
	int          idle_cycles = 0;
	int          errors = 0;
	int          n_sent = 0;
	int          n_checks = 0;
	int          n_fire_seen = 0;
	int          n_wait_seen = 0;
	int          most_fires = 0;

	initial begin
		for (int i = 0; i < NumSlots; i++) begin
			tmr_deadline[i] = '0;
			tmr_period[i] = '0;
			tmr_running[i] = 1'b0;
			tmr_queued[i] = 1'b0;
		end
	end

	// deadline arithmetic clips at the top of the 48-bit time range
	function automatic logic [pts_pkg::TimeW-1:0] sat_sum(
			input logic [pts_pkg::TimeW-1:0] a,
			input logic [pts_pkg::PeriodW-1:0] b);
		logic [pts_pkg::TimeW:0] s;
		s = {1'b0, a} + {{(pts_pkg::TimeW - pts_pkg::PeriodW + 1){1'b0}}, b};
		return s[pts_pkg::TimeW] ? TimeMax : s[pts_pkg::TimeW-1:0];
	endfunction

	function automatic void owe_beat(input logic k, input logic [pts_pkg::SlotW-1:0] s,
			input logic [pts_pkg::TimeW-1:0] w);
		sched_beat_t b;
		b.kind = k;
		b.fired_slot = s;
		b.wait_ms = w;
		b.last = (k == pts_pkg::KIND_WAIT);
		sched_reports = {sched_reports, b};
	endfunction

	// apply one accepted command to the bank and queue the beats it must produce
	function automatic void run_timer_cmd(input timer_cmd_t c);
		int best;
		int fires;
		bit done;
		fires = 0;
		done = 1'b0;
		case (c.cmd)
			pts_pkg::CMD_START: begin
				// a restart simply overwrites, the slot is never queued twice
				tmr_period[c.slot] = c.period;
				tmr_deadline[c.slot] = sat_sum(c.now, c.period);
				tmr_running[c.slot] = 1'b1;
				tmr_queued[c.slot] = 1'b1;
			end
			pts_pkg::CMD_STOP: begin
				// stale entry stays queued until it comes due
				tmr_running[c.slot] = 1'b0;
			end
			pts_pkg::CMD_CHECK: begin
				n_checks++;
				while (!done) begin
					// earliest queued deadline, lowest slot wins a tie
					best = -1;
					for (int i = 0; i < NumSlots; i++)
						if (tmr_queued[i] && (best < 0 || tmr_deadline[i] < tmr_deadline[best]))
							best = i;
					if (best < 0) begin
						owe_beat(pts_pkg::KIND_WAIT, '0, pts_pkg::EmptyWaitMs);
						done = 1'b1;
					end else if (tmr_deadline[best] > c.now) begin
						owe_beat(pts_pkg::KIND_WAIT, '0, tmr_deadline[best] - c.now);
						done = 1'b1;
					end else if (!tmr_running[best]) begin
						// stopped and due: dropped without a beat
						tmr_queued[best] = 1'b0;
					end else if (fires >= MaxFires) begin
						// still due after the firing cap: report no wait at all
						owe_beat(pts_pkg::KIND_WAIT, '0, '0);
						done = 1'b1;
					end else begin
						owe_beat(pts_pkg::KIND_FIRE, pts_pkg::SlotW'(best), '0);
						fires++;
						tmr_deadline[best] = sat_sum(tmr_deadline[best], tmr_period[best]);
					end
				end
				if (fires > most_fires)
					most_fires = fires;
			end
			default: begin
			end
		endcase
	endfunction

	// command driver: a beat moves when start is high and busy is low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				run_timer_cmd(cur_cmd);
				n_sent++;
				gap_left = cur_cmd.gap;
			end
			if (start && busy) begin
				// offered but not yet taken: hold everything
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_queue.size() > 0 && (!cmd_queue[0].drain
					|| (sched_reports.size() == 0 && !strobe))) begin
				// strobe is in the drain test so the pop order at this edge does not matter
				cur_cmd = cmd_queue.pop_front();
				start <= 1'b1;
				cmd <= cur_cmd.cmd;
				slot <= cur_cmd.slot;
				period_ms <= cur_cmd.period;
				now_ms <= cur_cmd.now;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name,
			input logic [pts_pkg::TimeW-1:0] want,
			input logic [pts_pkg::TimeW-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// result monitor: every strobed beat is taken on the spot
	always @(posedge clk) begin
		sched_beat_t want;
		if (arst_n && strobe) begin
			if (sched_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got kind %0b slot %0d wait %0h last %0b",
					$time, kind, fired_slot, wait_ms, last);
			end else begin
				want = sched_reports.pop_front();
				check_field("kind", pts_pkg::TimeW'(want.kind), pts_pkg::TimeW'(kind));
				check_field("fired_slot", pts_pkg::TimeW'(want.fired_slot),
					pts_pkg::TimeW'(fired_slot));
				check_field("wait_ms", want.wait_ms, wait_ms);
				check_field("last", pts_pkg::TimeW'(want.last), pts_pkg::TimeW'(last));
				if (want.kind == pts_pkg::KIND_FIRE)
					n_fire_seen++;
				else
					n_wait_seen++;
			end
		end
	end

	// watchdog: too long without a beat on either side means the block is stuck
	always @(posedge clk) begin
		if ((start && !busy) || strobe || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: no beat for %0d cycles, %0d reports outstanding",
				$time, IdleLimit, sched_reports.size());
			$display("[periodic_timer_scheduler_core] ERROR");
			$finish;
		end
	end

	bit calm = 1'b0;	// no sender gaps while set

	function automatic void add_cmd(input logic [pts_pkg::CmdW-1:0] c,
			input logic [pts_pkg::SlotW-1:0] s,
			input logic [pts_pkg::PeriodW-1:0] p, input logic [pts_pkg::TimeW-1:0] t,
			input bit hold);
		timer_cmd_t x;
		x.cmd = c;
		x.slot = s;
		x.period = p;
		x.now = t;
		x.drain = hold;
		x.gap = (!calm && $urandom_range(0, 99) < 33) ? $urandom_range(1, 12) : 0;
		cmd_queue = {cmd_queue, x};
	endfunction

	function automatic logic [pts_pkg::PeriodW-1:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return '0;
		else if (r < 75)
			return pts_pkg::PeriodW'($urandom_range(1, 300));
		else if (r < 90)
			return pts_pkg::PeriodW'($urandom_range(1, 5000));
		else
			return pts_pkg::PeriodW'($urandom);
	endfunction

	initial begin
		logic [pts_pkg::TimeW-1:0] tb_now;
		int n_real;
		int pick;
		bit hold;

		// empty bank, a stop with nothing running, an ignored command
		add_cmd(pts_pkg::CMD_CHECK, 3'd0, '0, '0, 1'b0);
		add_cmd(pts_pkg::CMD_STOP, 3'd0, '0, '0, 1'b0);
		add_cmd(CMD_NOP, 3'd5, '1, TimeMax, 1'b0);
		// tie on deadline: slot 0 before slot 7, with catch-up
		add_cmd(pts_pkg::CMD_START, 3'd7, 32'd1, 48'd0, 1'b0);
		add_cmd(pts_pkg::CMD_START, 3'd0, 32'd1, 48'd0, 1'b0);
		add_cmd(pts_pkg::CMD_CHECK, 3'd0, '0, 48'd3, 1'b0);
		// stopped timers and a restarted one are dropped silently
		add_cmd(pts_pkg::CMD_STOP, 3'd0, '0, '0, 1'b0);
		add_cmd(pts_pkg::CMD_STOP, 3'd7, '0, '0, 1'b0);
		add_cmd(pts_pkg::CMD_START, 3'd3, 32'd100, 48'd10, 1'b0);
		add_cmd(pts_pkg::CMD_START, 3'd3, 32'd50, 48'd10, 1'b0);
		add_cmd(pts_pkg::CMD_STOP, 3'd3, '0, '0, 1'b0);
		add_cmd(pts_pkg::CMD_CHECK, 3'd0, '0, 48'd200, 1'b0);
		// zero period runs into the firing cap; a long wait from the widest period
		add_cmd(pts_pkg::CMD_START, 3'd2, 32'd0, 48'd300, 1'b0);
		add_cmd(pts_pkg::CMD_START, 3'd6, '1, 48'd0, 1'b0);
		add_cmd(pts_pkg::CMD_CHECK, 3'd0, '0, 48'd300, 1'b0);
		add_cmd(pts_pkg::CMD_STOP, 3'd2, '0, '0, 1'b1);
		add_cmd(pts_pkg::CMD_CHECK, 3'd0, '0, 48'd301, 1'b0);
		// a deadline clipped at the top of time, and a check at the top of time
		add_cmd(pts_pkg::CMD_START, 3'd5, '1, TimeMax - 48'd5, 1'b0);
		add_cmd(pts_pkg::CMD_START, 3'd1, 32'h8000_0000, 48'h7fff_ffff_ffff, 1'b0);
		add_cmd(pts_pkg::CMD_CHECK, 3'd0, '0, TimeMax, 1'b0);
		add_cmd(pts_pkg::CMD_STOP, 3'd1, '0, '0, 1'b0);
		add_cmd(pts_pkg::CMD_STOP, 3'd5, '0, '0, 1'b0);
		add_cmd(pts_pkg::CMD_STOP, 3'd6, '0, '0, 1'b0);
		add_cmd(pts_pkg::CMD_CHECK, 3'd0, '0, TimeMax, 1'b0);
		add_cmd(pts_pkg::CMD_START, 3'd4, 32'd1, TimeMax, 1'b0);
		add_cmd(pts_pkg::CMD_CHECK, 3'd0, '0, '0, 1'b0);

		// random traffic: mostly a sane clock moving forward, now and then a jump
		tb_now = 48'd1000;
		n_real = 0;
		while (n_real < 245) begin
			calm = (n_real >= 100 && n_real < 160);
			hold = (n_real % 40 == 39);
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				add_cmd(pts_pkg::CMD_START, pts_pkg::SlotW'($urandom_range(0, NumSlots - 1)),
					pick_period(), tb_now + pts_pkg::TimeW'($urandom_range(0, 20)), hold);
				n_real++;
			end else if (pick < 52) begin
				add_cmd(pts_pkg::CMD_STOP, pts_pkg::SlotW'($urandom_range(0, NumSlots - 1)),
					pts_pkg::PeriodW'($urandom), pts_pkg::TimeW'({$urandom, $urandom}), hold);
				n_real++;
			end else if (pick < 94) begin
				tb_now = tb_now + pts_pkg::TimeW'($urandom_range(0, 400));
				add_cmd(pts_pkg::CMD_CHECK, pts_pkg::SlotW'($urandom),
					pts_pkg::PeriodW'($urandom), tb_now, hold);
				n_real++;
			end else if (pick < 97) begin
				add_cmd(CMD_NOP, pts_pkg::SlotW'($urandom), pts_pkg::PeriodW'($urandom),
					pts_pkg::TimeW'({$urandom, $urandom}), 1'b0);
			end else begin
				// clock jumps anywhere, sometimes right under the top
				if ($urandom_range(0, 1))
					tb_now = pts_pkg::TimeW'({$urandom, $urandom});
				else
					tb_now = TimeMax - pts_pkg::TimeW'($urandom_range(0, 1000));
				add_cmd(pts_pkg::CMD_CHECK, pts_pkg::SlotW'($urandom),
					pts_pkg::PeriodW'($urandom), tb_now, hold);
				n_real++;
			end
		end
		calm = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || start)
			@(posedge clk);
		while (sched_reports.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("%0d commands taken, %0d of them checks; %0d fire beats and %0d wait beats compared",
			n_sent, n_checks, n_fire_seen, n_wait_seen);
		$display("busiest check fired %0d times", most_fires);
		if (errors == 0)
			$display("[periodic_timer_scheduler_core] OK");
		else
			$display("[periodic_timer_scheduler_core] ERROR");
		$finish;
	end

endmodule
